/* rtl/core/symbol_row_statistics_collector_macros.svh */
// Assertion helpers shared by the statistics collector modules.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef SYMBOL_ROW_STATISTICS_COLLECTOR_MACROS_SVH
`define SYMBOL_ROW_STATISTICS_COLLECTOR_MACROS_SVH

// Same-cycle implication.
`define SRSC_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SRSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/srsc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srsc_pkg
// Types, sizes and codes shared by the symbol row statistics collector.
// ----------------------------------------------------------------------------
package srsc_pkg;

	// Store sizes
	localparam int ROW_COUNT     = 64;
	localparam int RATIO_DEPTH   = 11;
	localparam int COUNTER_WIDTH = 32;
	localparam int JUMP_CLASSES  = 8;
	localparam int QUEUE_DEPTH   = 2;

	// Field widths
	localparam int OPCODE_W = 2;
	localparam int ROW_W    = 6;
	localparam int ENERGY_W = 48;
	localparam int TABLE_W  = 2;
	localparam int INDEX_W  = 6;
	localparam int VALUE_W  = 32;
	localparam int BIN_W    = 6;

	// Derived widths
	localparam int ROW_AW   = $clog2(ROW_COUNT);
	localparam int RATIO_AW = $clog2(RATIO_DEPTH);
	localparam int JUMP_AW  = $clog2(JUMP_CLASSES);
	localparam int DEN_W    = ENERGY_W - 1;
	localparam int NUM_W    = ENERGY_W + 3;

	// Opcodes
	localparam logic [OPCODE_W-1:0] OP_RECORD = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_READ   = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

	// Read tables
	localparam logic [TABLE_W-1:0] TBL_ROWS   = 2'd0;
	localparam logic [TABLE_W-1:0] TBL_RATIO  = 2'd1;
	localparam logic [TABLE_W-1:0] TBL_JUMP   = 2'd2;
	localparam logic [TABLE_W-1:0] TBL_TOTALS = 2'd3;

	// Totals indexes
	localparam logic [INDEX_W-1:0] TOT_SYMBOLS = 6'd0;
	localparam logic [INDEX_W-1:0] TOT_IN      = 6'd1;
	localparam logic [INDEX_W-1:0] TOT_OUT     = 6'd2;

	typedef enum logic [1:0] {
		K_RECORD,
		K_READ,
		K_CLEAR,
		K_NOP
	} kind_t;

	typedef enum logic [2:0] {
		BS_IDLE,
		BS_DIV,
		BS_RD,
		BS_WR,
		BS_FIN
	} back_state_t;

	typedef struct packed {
		logic [OPCODE_W-1:0]        opcode;
		logic [ROW_W-1:0]           top_row;
		logic signed [ENERGY_W-1:0] top_energy;
		logic signed [ENERGY_W-1:0] second_energy;
		logic                       expected_allowed;
		logic [TABLE_W-1:0]         read_table;
		logic [INDEX_W-1:0]         read_index;
	} item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] read_value;
		logic [BIN_W-1:0]   ratio_bin;
		logic [JUMP_AW-1:0] jump_class;
		logic               jump_counted;
	} result_t;

	// Classified command handed from front to back
	typedef struct packed {
		kind_t              kind;
		logic [ROW_AW-1:0]  addr;
		logic [TABLE_W-1:0] read_table;
		logic [INDEX_W-1:0] read_index;
		logic               rd_ok;
		logic               allowed;
		logic               div_en;
		logic [NUM_W-1:0]   numer;
		logic [DEN_W-1:0]   denom;
		logic               jump_en;
		logic [JUMP_AW-1:0] jump_class;
	} work_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage
`default_nettype wire

/* rtl/core/srsc_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srsc_front
// Accepts commands, classifies them and tracks the previous winning row.
// ----------------------------------------------------------------------------
module srsc_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire srsc_pkg::item_t     cmd,
	input  wire srsc_pkg::q_status_t status,
	output logic                     busy,
	output logic                     push,
	output srsc_pkg::work_t          push_data
);

	localparam int ROW_W   = srsc_pkg::ROW_W;
	localparam int E_W     = srsc_pkg::ENERGY_W;
	localparam int NUM_W   = srsc_pkg::NUM_W;
	localparam int JUMP_AW = srsc_pkg::JUMP_AW;

	logic [ROW_W-1:0] prev_row_q;
	logic             prev_valid_q;
	logic [ROW_W-1:0] row_gap;
	logic             row_ok;

	// Six-bit rows never reach the widest class.
	function automatic logic [JUMP_AW-1:0] jump_of(input logic [ROW_W-1:0] d);
		logic [JUMP_AW-1:0] c;
		if (d == '0)
			c = JUMP_AW'(0);
		else if (d <= ROW_W'(4))
			c = JUMP_AW'(1);
		else if (d <= ROW_W'(8))
			c = JUMP_AW'(2);
		else if (d <= ROW_W'(16))
			c = JUMP_AW'(3);
		else if (d <= ROW_W'(32))
			c = JUMP_AW'(4);
		else if (d <= ROW_W'(48))
			c = JUMP_AW'(5);
		else
			c = JUMP_AW'(6);
		return c;
	endfunction

	assign busy = status.full;
	assign push = start && !status.full;

	assign row_ok  = 32'(cmd.top_row) < srsc_pkg::ROW_COUNT;
	assign row_gap = (cmd.top_row > prev_row_q) ? (cmd.top_row - prev_row_q)
	                                            : (prev_row_q - cmd.top_row);

	always_comb begin
		push_data = '0;
		case (cmd.opcode)
			srsc_pkg::OP_RECORD: push_data.kind = row_ok ? srsc_pkg::K_RECORD : srsc_pkg::K_NOP;
			srsc_pkg::OP_READ:   push_data.kind = srsc_pkg::K_READ;
			srsc_pkg::OP_CLEAR:  push_data.kind = srsc_pkg::K_CLEAR;
			default:             push_data.kind = srsc_pkg::K_NOP;
		endcase

		push_data.addr = (cmd.opcode == srsc_pkg::OP_READ) ? srsc_pkg::ROW_AW'(cmd.read_index)
		                                                  : srsc_pkg::ROW_AW'(cmd.top_row);
		push_data.read_table = cmd.read_table;
		push_data.read_index = cmd.read_index;

		case (cmd.read_table)
			srsc_pkg::TBL_ROWS:  push_data.rd_ok = 32'(cmd.read_index) < srsc_pkg::ROW_COUNT;
			srsc_pkg::TBL_RATIO: push_data.rd_ok = 32'(cmd.read_index) < srsc_pkg::RATIO_DEPTH;
			srsc_pkg::TBL_JUMP:  push_data.rd_ok = 32'(cmd.read_index) < srsc_pkg::JUMP_CLASSES;
			default:             push_data.rd_ok = cmd.read_index <= srsc_pkg::TOT_OUT;
		endcase

		push_data.allowed = cmd.expected_allowed;

		// Divide only for a positive top and a non-negative second energy.
		push_data.div_en = !cmd.top_energy[E_W-1] && (|cmd.top_energy[E_W-2:0])
		                   && !cmd.second_energy[E_W-1];
		push_data.numer  = NUM_W'({cmd.second_energy[E_W-2:0], 3'b000})
		                 + NUM_W'({cmd.second_energy[E_W-2:0], 1'b0});
		push_data.denom  = cmd.top_energy[E_W-2:0];

		push_data.jump_en    = prev_valid_q;
		push_data.jump_class = prev_valid_q ? jump_of(row_gap) : '0;
	end

	// Advance the previous row in command order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_row_q   <= '0;
			prev_valid_q <= 1'b0;
		end else if (push) begin
			if (cmd.opcode == srsc_pkg::OP_RECORD && row_ok) begin
				prev_row_q   <= cmd.top_row;
				prev_valid_q <= 1'b1;
			end else if (cmd.opcode == srsc_pkg::OP_CLEAR) begin
				prev_row_q   <= '0;
				prev_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/srsc_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srsc_queue
// Short FIFO of classified commands between front and back.
// ----------------------------------------------------------------------------
`include "symbol_row_statistics_collector_macros.svh"
module srsc_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire srsc_pkg::work_t     push_data,
	input  wire logic                pop,
	output srsc_pkg::work_t          pop_data,
	output srsc_pkg::q_status_t      status
);

	localparam int DEPTH  = srsc_pkg::QUEUE_DEPTH;
	localparam int QA_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int QCNT_W = $clog2(DEPTH + 1);

	srsc_pkg::work_t   entry_q [DEPTH];
	logic [QA_W-1:0]   wr_ptr_q;
	logic [QA_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign pop_data     = entry_q[rd_ptr_q];
	assign status.full  = count_q == QCNT_W'(DEPTH);
	assign status.empty = count_q == '0;

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QA_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QA_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	`SRSC_ASSERT_IMPLY(a_no_overflow, push, count_q != QCNT_W'(DEPTH), "push into full queue")
	`SRSC_ASSERT_IMPLY(a_no_underflow, pop, count_q != '0, "pop from empty queue")

endmodule
`default_nettype wire

/* rtl/core/srsc_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srsc_back
// Executes queued commands: ratio divider, counter stores, result register.
// ----------------------------------------------------------------------------
`include "symbol_row_statistics_collector_macros.svh"
module srsc_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire srsc_pkg::q_status_t status,
	input  wire srsc_pkg::work_t     head,
	output logic                     pop,
	output logic                     done,
	output srsc_pkg::result_t        result
);

	localparam int CNT_W    = srsc_pkg::COUNTER_WIDTH;
	localparam int ROWS     = srsc_pkg::ROW_COUNT;
	localparam int BINS     = srsc_pkg::RATIO_DEPTH;
	localparam int JUMPS    = srsc_pkg::JUMP_CLASSES;
	localparam int RATIO_AW = srsc_pkg::RATIO_AW;
	localparam int JUMP_AW  = srsc_pkg::JUMP_AW;
	localparam int CMP_W    = srsc_pkg::NUM_W + RATIO_AW;
	localparam int STEP_W   = $clog2(RATIO_AW + 1);
	localparam logic [RATIO_AW:0] RB_MAX = (RATIO_AW + 1)'(BINS - 1);

	srsc_pkg::back_state_t state_q, state_nxt;
	srsc_pkg::work_t       work_q;

	// Divider
	logic [CMP_W-1:0]    rem_q;
	logic [CMP_W-1:0]    dsh_q;
	logic [RATIO_AW:0]   quo_q;
	logic [STEP_W-1:0]   step_q;
	logic                ge;

	// Stores
	logic [CNT_W-1:0]    row_mem [ROWS];
	logic [ROWS-1:0]     row_vld_q;
	logic [CNT_W-1:0]    rd_data_q;
	logic                rd_vld_q;
	logic [CNT_W-1:0]    ratio_q [BINS];
	logic [CNT_W-1:0]    jump_q [JUMPS];
	logic [CNT_W-1:0]    sym_q;
	logic [CNT_W-1:0]    in_q;
	logic [CNT_W-1:0]    out_q;

	// Control
	logic                mem_re;
	logic                rec_we;
	logic                clr;
	logic                done_nxt;
	logic                done_q;
	srsc_pkg::result_t   result_nxt;
	srsc_pkg::result_t   result_q;

	logic [RATIO_AW-1:0] rb;
	logic [RATIO_AW-1:0] ratio_addr;
	logic [JUMP_AW-1:0]  jump_addr;
	logic [CNT_W-1:0]    row_old;
	logic [CNT_W-1:0]    ratio_old;
	logic [CNT_W-1:0]    jump_old;
	logic [CNT_W-1:0]    read_val;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	assign ge = rem_q >= dsh_q;
	assign rb = (quo_q >= RB_MAX) ? RB_MAX[RATIO_AW-1:0] : quo_q[RATIO_AW-1:0];

	assign ratio_addr = (work_q.kind == srsc_pkg::K_READ) ? work_q.read_index[RATIO_AW-1:0] : rb;
	assign jump_addr  = (work_q.kind == srsc_pkg::K_READ) ? work_q.read_index[JUMP_AW-1:0]
	                                                      : work_q.jump_class;
	assign row_old    = rd_vld_q ? rd_data_q : '0;
	assign ratio_old  = ratio_q[ratio_addr];
	assign jump_old   = jump_q[jump_addr];

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			srsc_pkg::BS_IDLE: begin
				if (!status.empty) begin
					case (head.kind)
						srsc_pkg::K_RECORD: state_nxt = head.div_en ? srsc_pkg::BS_DIV
						                                            : srsc_pkg::BS_RD;
						srsc_pkg::K_READ:   state_nxt = srsc_pkg::BS_RD;
						default:            state_nxt = srsc_pkg::BS_FIN;
					endcase
				end
			end
			srsc_pkg::BS_DIV: state_nxt = (step_q == '0) ? srsc_pkg::BS_RD : srsc_pkg::BS_DIV;
			srsc_pkg::BS_RD:  state_nxt = srsc_pkg::BS_WR;
			srsc_pkg::BS_WR:  state_nxt = srsc_pkg::BS_IDLE;
			srsc_pkg::BS_FIN: state_nxt = srsc_pkg::BS_IDLE;
			default:          state_nxt = srsc_pkg::BS_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		pop        = (state_q == srsc_pkg::BS_IDLE) && !status.empty;
		mem_re     = state_q == srsc_pkg::BS_RD;
		rec_we     = (state_q == srsc_pkg::BS_WR) && (work_q.kind == srsc_pkg::K_RECORD);
		clr        = (state_q == srsc_pkg::BS_FIN) && (work_q.kind == srsc_pkg::K_CLEAR);
		done_nxt   = (state_q == srsc_pkg::BS_WR) || (state_q == srsc_pkg::BS_FIN);
		result_nxt = '0;

		case (work_q.read_table)
			srsc_pkg::TBL_ROWS:  read_val = row_old;
			srsc_pkg::TBL_RATIO: read_val = ratio_old;
			srsc_pkg::TBL_JUMP:  read_val = jump_old;
			default: begin
				case (work_q.read_index)
					srsc_pkg::TOT_SYMBOLS: read_val = sym_q;
					srsc_pkg::TOT_IN:      read_val = in_q;
					srsc_pkg::TOT_OUT:     read_val = out_q;
					default:               read_val = '0;
				endcase
			end
		endcase

		if (state_q == srsc_pkg::BS_WR) begin
			if (work_q.kind == srsc_pkg::K_RECORD) begin
				result_nxt.ratio_bin    = srsc_pkg::BIN_W'(rb);
				result_nxt.jump_class   = work_q.jump_en ? work_q.jump_class : '0;
				result_nxt.jump_counted = work_q.jump_en;
			end else if (work_q.rd_ok) begin
				result_nxt.read_value = srsc_pkg::VALUE_W'(read_val);
			end
		end
	end

	// State, divider and command registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srsc_pkg::BS_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= done_nxt;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_nxt;
		if (pop) begin
			work_q <= head;
			rem_q  <= CMP_W'(head.numer);
			dsh_q  <= CMP_W'(head.denom) << RATIO_AW;
			quo_q  <= '0;
			step_q <= STEP_W'(RATIO_AW);
		end else if (state_q == srsc_pkg::BS_DIV) begin
			// One restoring step per cycle, quotient MSB first.
			rem_q  <= ge ? rem_q - dsh_q : rem_q;
			dsh_q  <= dsh_q >> 1;
			quo_q  <= {quo_q[RATIO_AW-1:0], ge};
			step_q <= step_q - 1'b1;
		end
	end

	// Row count memory
	always_ff @(posedge clk) begin
		if (rec_we)
			row_mem[work_q.addr] <= sat_inc(row_old);
		if (mem_re) begin
			rd_data_q <= row_mem[work_q.addr];
			rd_vld_q  <= row_vld_q[work_q.addr];
		end
	end

	// Valid bits, small histograms and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			for (int i = 0; i < BINS; i++)
				ratio_q[i] <= '0;
			for (int i = 0; i < JUMPS; i++)
				jump_q[i] <= '0;
			sym_q <= '0;
			in_q  <= '0;
			out_q <= '0;
		end else if (clr) begin
			row_vld_q <= '0;
			for (int i = 0; i < BINS; i++)
				ratio_q[i] <= '0;
			for (int i = 0; i < JUMPS; i++)
				jump_q[i] <= '0;
			sym_q <= '0;
			in_q  <= '0;
			out_q <= '0;
		end else if (rec_we) begin
			row_vld_q[work_q.addr] <= 1'b1;
			ratio_q[ratio_addr]    <= sat_inc(ratio_old);
			if (work_q.jump_en)
				jump_q[jump_addr] <= sat_inc(jump_old);
			sym_q <= sat_inc(sym_q);
			if (work_q.allowed)
				in_q <= sat_inc(in_q);
			else
				out_q <= sat_inc(out_q);
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`SRSC_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "result strobe held past one cycle")
	`SRSC_ASSERT_IMPLY(a_div_record, state_q == srsc_pkg::BS_DIV, work_q.kind == srsc_pkg::K_RECORD && work_q.div_en, "divider running without a dividing record")
	`SRSC_ASSERT_NEXT(a_div_exit, state_q == srsc_pkg::BS_DIV && step_q == '0, state_q == srsc_pkg::BS_RD, "divider did not hand over after last step")

endmodule
`default_nettype wire

/* rtl/core/symbol_row_statistics_collector.sv */
`timescale 1ns / 1ps
`default_nettype none
// Back-end flow: a record with a division runs the 5-step restoring ratio divider,
// then reads and writes its counters; a record without one, or a read, goes
// straight to the read and write states; a clear or an ignored command goes to
// the finish state. A two-entry queue takes commands meanwhile; busy = queue full.
// Reset (arst_n low, asynchronous) clears counters, row valid bits, previous row
// and the queue; results cannot be held off and are valid only while done is high.
// ----------------------------------------------------------------------------
// symbol_row_statistics_collector
// Counts decoded symbols per row, ratio bin, jump class and allowed flag.
// ----------------------------------------------------------------------------
module symbol_row_statistics_collector (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire srsc_pkg::item_t   cmd,
	output logic                   done,
	output srsc_pkg::result_t      result
);

	// Front to queue transfer
	logic                push;
	srsc_pkg::work_t     push_data;

	// Queue to back transfer
	logic                pop;
	srsc_pkg::work_t     head;
	srsc_pkg::q_status_t status;

	// Front: accept a command when the queue has room, classify it (opcode,
	// range checks, divide enable, ten times the second energy) and work out
	// the jump class against the previous row, which it advances in order.
	srsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.status    (status),
		.busy      (busy),
		.push      (push),
		.push_data (push_data)
	);

	// Queue: hold classified commands so the front keeps taking transfers
	// while the back end divides or updates counters.
	srsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (head),
		.status    (status)
	);

	// Back: pop one command at a time, run the ratio divider for records with divide enable,
	// read-modify-write the counter stores and drive the one-cycle result.
	srsc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.head   (head),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

endmodule
`default_nettype wire

/* dv/tb_symbol_row_statistics_collector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_symbol_row_statistics_collector
// Self-checking bench for the symbol statistics collector. Every command that
// the block takes is run through a local copy of its counters, so the bench
// knows the result it must report. Each strobed result is compared in order
// against that prediction. Directed commands cover the edges of the fields.
// Random traffic follows, with gaps on the command side.
// ----------------------------------------------------------------------------
module tb_symbol_row_statistics_collector;
	import srsc_pkg::*;

	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
	localparam logic signed [ENERGY_W-1:0] E_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
	localparam logic signed [ENERGY_W-1:0] E_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};
	localparam int MAX_GAP = 8;
	localparam int REPORT_LIMIT = 10;
	localparam int ITEM_W = $bits(item_t);

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   cmd;
	logic    done;
	result_t result;

	symbol_row_statistics_collector uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	// Local copy of the counters, updated as each command is accepted
	bit [COUNTER_WIDTH-1:0] row_tally [ROW_COUNT];
	bit [COUNTER_WIDTH-1:0] ratio_tally [RATIO_DEPTH];
	bit [COUNTER_WIDTH-1:0] jump_tally [JUMP_CLASSES];
	bit [COUNTER_WIDTH-1:0] symbol_tally, in_tally, out_tally;
	bit [ROW_W-1:0]         last_row;
	bit                     last_row_valid;

	// Results that the block still owes, oldest first
	result_t results_due [$];

	int  failures;
	int  results_checked;
	int  n_record, n_read, n_clear, n_unused;
	bit [RATIO_DEPTH-1:0]  bins_seen;
	bit [JUMP_CLASSES-1:0] classes_seen;
	bit  idle_on;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Keep the run bounded even if the block stops answering
	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic bit [COUNTER_WIDTH-1:0] sat_inc(bit [COUNTER_WIDTH-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	// floor(10 * second / top), clamped to the top bin; zero for a
	// non-positive top or a negative second
	function automatic bit [BIN_W-1:0] ratio_bin_of(logic signed [ENERGY_W-1:0] top,
			logic signed [ENERGY_W-1:0] second);
		bit [63:0] quot;
		if (top <= 0 || second < 0)
			return '0;
		quot = ({16'd0, second} * 64'd10) / {16'd0, top};
		if (quot >= 64'(RATIO_DEPTH - 1))
			quot = 64'(RATIO_DEPTH - 1);
		return quot[BIN_W-1:0];
	endfunction

	function automatic bit [JUMP_AW-1:0] jump_class_of(int unsigned d);
		if (d == 0)  return 3'd0;
		if (d <= 4)  return 3'd1;
		if (d <= 8)  return 3'd2;
		if (d <= 16) return 3'd3;
		if (d <= 32) return 3'd4;
		if (d <= 48) return 3'd5;
		if (d <= 63) return 3'd6;
		return 3'd7;
	endfunction

	function automatic bit [COUNTER_WIDTH-1:0] counter_at(logic [TABLE_W-1:0] tbl,
			logic [INDEX_W-1:0] idx);
		case (tbl)
			TBL_ROWS:  return (idx < ROW_COUNT) ? row_tally[idx] : '0;
			TBL_RATIO: return (idx < RATIO_DEPTH) ? ratio_tally[idx] : '0;
			TBL_JUMP:  return (idx < JUMP_CLASSES) ? jump_tally[idx] : '0;
			default: begin
				case (idx)
					TOT_SYMBOLS: return symbol_tally;
					TOT_IN:      return in_tally;
					TOT_OUT:     return out_tally;
					default:     return '0;
				endcase
			end
		endcase
	endfunction

	function automatic void clear_tallies();
		foreach (row_tally[i]) row_tally[i] = '0;
		foreach (ratio_tally[i]) ratio_tally[i] = '0;
		foreach (jump_tally[i]) jump_tally[i] = '0;
		symbol_tally   = '0;
		in_tally       = '0;
		out_tally      = '0;
		last_row       = '0;
		last_row_valid = 1'b0;
	endfunction

	// Apply one accepted command to the local counters and return the result
	// the block has to report for it
	function automatic result_t apply_command(item_t it);
		result_t r;
		bit [BIN_W-1:0]   rb;
		bit [JUMP_AW-1:0] jc;
		int unsigned      d;
		r = '0;
		case (it.opcode)
			OP_RECORD: begin
				n_record++;
				// a row past the table is dropped without a trace
				if (it.top_row < ROW_COUNT) begin
					symbol_tally = sat_inc(symbol_tally);
					row_tally[it.top_row] = sat_inc(row_tally[it.top_row]);
					if (it.expected_allowed)
						in_tally = sat_inc(in_tally);
					else
						out_tally = sat_inc(out_tally);
					rb = ratio_bin_of(it.top_energy, it.second_energy);
					ratio_tally[rb] = sat_inc(ratio_tally[rb]);
					bins_seen[rb] = 1'b1;
					jc = '0;
					if (last_row_valid) begin
						d = (it.top_row > last_row) ? it.top_row - last_row
							: last_row - it.top_row;
						jc = jump_class_of(d);
						jump_tally[jc] = sat_inc(jump_tally[jc]);
						classes_seen[jc] = 1'b1;
						r.jump_counted = 1'b1;
					end
					last_row       = it.top_row;
					last_row_valid = 1'b1;
					r.ratio_bin    = rb;
					r.jump_class   = jc;
				end
			end
			OP_READ: begin
				n_read++;
				r.read_value = counter_at(it.read_table, it.read_index);
			end
			OP_CLEAR: begin
				n_clear++;
				clear_tallies();
			end
			default: n_unused++;
		endcase
		return r;
	endfunction

	function automatic item_t make_record(logic [ROW_W-1:0] row,
			logic signed [ENERGY_W-1:0] top, logic signed [ENERGY_W-1:0] second,
			logic allowed);
		item_t it;
		// fill the unused fields with noise; they must not matter
		it                  = ITEM_W'({$urandom(), $urandom(), $urandom(), $urandom()});
		it.opcode           = OP_RECORD;
		it.top_row          = row;
		it.top_energy       = top;
		it.second_energy    = second;
		it.expected_allowed = allowed;
		return it;
	endfunction

	function automatic item_t make_read(logic [TABLE_W-1:0] tbl, logic [INDEX_W-1:0] idx);
		item_t it;
		it            = ITEM_W'({$urandom(), $urandom(), $urandom(), $urandom()});
		it.opcode     = OP_READ;
		it.read_table = tbl;
		it.read_index = idx;
		return it;
	endfunction

	function automatic item_t make_plain(logic [OPCODE_W-1:0] op);
		item_t it;
		it        = ITEM_W'({$urandom(), $urandom(), $urandom(), $urandom()});
		it.opcode = op;
		return it;
	endfunction

	// Random command, weighted toward records with energies spread over all bins
	function automatic item_t rand_command();
		item_t       it;
		int unsigned sel;
		bit [63:0]   top, second, tenth;
		int unsigned lim;
		it  = ITEM_W'({$urandom(), $urandom(), $urandom(), $urandom()});
		sel = $urandom_range(99);
		if (sel < 62) begin
			it.opcode = OP_RECORD;
			if ($urandom_range(9) == 0)
				it.top_row = last_row;
			case ($urandom_range(5))
				0: ;
				1: begin
					// aim at a chosen bin, top anywhere from tiny to full scale
					top = {$urandom(), $urandom()} & ((64'd1 << (ENERGY_W - 1)) - 1);
					top = top >> $urandom_range(ENERGY_W - 2);
					if (top == 0)
						top = 1;
					tenth  = top / 10;
					second = (top * $urandom_range(RATIO_DEPTH - 1)) / 10;
					if (tenth != 0)
						second = second + ({$urandom(), $urandom()} % tenth);
					it.top_energy    = top[ENERGY_W-1:0];
					it.second_energy = second[ENERGY_W-1:0];
				end
				2: begin
					it.top_energy = $urandom_range(1) ? '0 : {1'b1, it.top_energy[ENERGY_W-2:0]};
				end
				3: it.second_energy = {1'b1, it.second_energy[ENERGY_W-2:0]};
				4: begin
					it.top_energy    = ENERGY_W'($urandom_range(20));
					it.second_energy = ENERGY_W'($urandom_range(20));
				end
				default: begin
					it.top_energy    = ENERGY_W'($urandom_range(1, 1000));
					it.second_energy = {1'b0, it.second_energy[ENERGY_W-2:0]};
				end
			endcase
		end else if (sel < 90) begin
			it.opcode = OP_READ;
			if ($urandom_range(9) < 7) begin
				case (it.read_table)
					TBL_ROWS:  lim = ROW_COUNT - 1;
					TBL_RATIO: lim = RATIO_DEPTH - 1;
					TBL_JUMP:  lim = JUMP_CLASSES - 1;
					default:   lim = 2;
				endcase
				it.read_index = INDEX_W'($urandom_range(lim));
			end
		end else if (sel < 92) begin
			it.opcode = OP_CLEAR;
		end else begin
			it.opcode = OP_UNUSED;
		end
		return it;
	endfunction

	// Present one command and hold it until the block takes it. Start is left
	// high so back-to-back commands need no second assignment in one step.
	task automatic send_item(item_t it);
		int gap;
		gap = 0;
		if (idle_on) begin
			while ($urandom_range(99) < 22 && gap < MAX_GAP) begin
				start <= 1'b0;
				@(posedge clk);
				gap++;
			end
		end
		start <= 1'b1;
		cmd   <= it;
		do
			@(posedge clk);
		while (busy);
		results_due.push_back(apply_command(it));
	endtask

	// Drop start and wait until every owed result has come back
	task automatic wait_for_drain();
		start <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic note_failure(string what);
		failures++;
		if (failures <= REPORT_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// Compare every strobed result with the oldest prediction
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && done === 1'b1) begin
			if (results_due.size() == 0) begin
				note_failure($sformatf("result with nothing owed: %p", result));
			end else begin
				want = results_due.pop_front();
				results_checked++;
				if (result.read_value !== want.read_value
						|| result.ratio_bin !== want.ratio_bin
						|| result.jump_class !== want.jump_class
						|| result.jump_counted !== want.jump_counted)
					note_failure($sformatf({"value exp %0d got %0d, bin exp %0d got %0d, ",
						"class exp %0d got %0d, counted exp %0b got %0b"},
						want.read_value, result.read_value, want.ratio_bin,
						result.ratio_bin, want.jump_class, result.jump_class,
						want.jump_counted, result.jump_counted));
			end
		end
	end

	// Walk the jump classes through a row sequence while hitting the energy
	// corners: full scale, zero, negative top, negative second, clamp
	task automatic test_record_extremes();
		send_item(make_record(6'd0,  E_MAX, E_MAX, 1'b1));
		send_item(make_record(6'd0,  48'sd1, 48'sd0, 1'b0));
		send_item(make_record(6'd4,  48'sd0, 48'sd5, 1'b1));
		send_item(make_record(6'd12, E_MIN, E_MAX, 1'b0));
		send_item(make_record(6'd28, 48'sd10, -48'sd1, 1'b1));
		send_item(make_record(6'd60, 48'sd10, 48'sd9, 1'b0));
		send_item(make_record(6'd12, 48'sd3, 48'sd1, 1'b1));
		send_item(make_record(6'd63, 48'sd7, E_MAX, 1'b0));
		send_item(make_record(6'd63, E_MAX, E_MIN, 1'b1));
		send_item(make_record(6'd63, E_MAX, E_MAX - 1, 1'b0));
	endtask

	// Read every totals slot and the edges of each table, both sides of range where the index width allows
	task automatic test_read_ranges();
		send_item(make_read(TBL_TOTALS, TOT_SYMBOLS));
		send_item(make_read(TBL_TOTALS, TOT_IN));
		send_item(make_read(TBL_TOTALS, TOT_OUT));
		send_item(make_read(TBL_TOTALS, 6'd63));
		send_item(make_read(TBL_RATIO, INDEX_W'(RATIO_DEPTH - 1)));
		send_item(make_read(TBL_RATIO, INDEX_W'(RATIO_DEPTH)));
		send_item(make_read(TBL_JUMP, INDEX_W'(JUMP_CLASSES - 1)));
		send_item(make_read(TBL_JUMP, INDEX_W'(JUMP_CLASSES)));
		send_item(make_read(TBL_ROWS, 6'd63));
	endtask

	// The spare opcode must leave every counter alone
	task automatic test_unused_opcode();
		send_item(make_plain(OP_UNUSED));
		send_item(make_read(TBL_TOTALS, TOT_SYMBOLS));
	endtask

	// After a clear the counters read zero and the next record has no jump
	task automatic test_clear();
		send_item(make_plain(OP_CLEAR));
		send_item(make_read(TBL_TOTALS, TOT_SYMBOLS));
		send_item(make_read(TBL_ROWS, 6'd63));
		send_item(make_record(6'd33, 48'sd100, 48'sd55, 1'b1));
	endtask

	// Random traffic; now and then hold off until the block has answered all
	task automatic test_random_traffic(int count);
		for (int i = 0; i < count; i++) begin
			send_item(rand_command());
			if ($urandom_range(99) == 0)
				wait_for_drain();
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		start           = 1'b0;
		cmd             = '0;
		failures        = 0;
		results_checked = 0;
		n_record        = 0;
		n_read          = 0;
		n_clear         = 0;
		n_unused        = 0;
		bins_seen       = '0;
		classes_seen    = '0;
		idle_on         = 1'b1;
		clear_tallies();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_record_extremes();
		test_read_ranges();
		test_unused_opcode();
		test_clear();
		wait_for_drain();

		test_random_traffic(400);
		// long stretch with the sender never idling
		idle_on = 1'b0;
		test_random_traffic(250);
		idle_on = 1'b1;
		test_random_traffic(380);

		wait_for_drain();
		repeat (12) @(posedge clk);

		$display("Covered %0d records, %0d reads, %0d clears, %0d spare opcodes; %0d results checked.",
			n_record, n_read, n_clear, n_unused, results_checked);
		$display("Ratio bins hit %b, jump classes hit %b, mismatches %0d.",
			bins_seen, classes_seen, failures);
		if (failures == 0 && results_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/srsc_pkg.sv
rtl/core/srsc_front.sv
rtl/core/srsc_queue.sv
rtl/core/srsc_back.sv
rtl/core/symbol_row_statistics_collector.sv
dv/tb_symbol_row_statistics_collector.sv
